>>> rtl/substring_match_positions_macros.svh
// Assertion helpers for the RTL that carries checks.
`ifndef SUBSTRING_MATCH_POSITIONS_MACROS_SVH
`define SUBSTRING_MATCH_POSITIONS_MACROS_SVH

// Same-cycle implication, disabled while rst_cond is high.
`define SMP_ASSERT_NOW(label, clk, rst_cond, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst_cond) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled while rst_cond is high.
`define SMP_ASSERT_NEXT(label, clk, rst_cond, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst_cond) (cond) |=> (conseq)) \
      else $error(msg);

`endif

>>> rtl/smp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smp_pkg;

   localparam int PATTERN_MAX_DEFAULT   = 16;
   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int LEN_BITS              = 5;
   localparam int PATTERN_BITS          = 128;
   localparam int CSR_ADDR_BITS         = 5;
   localparam int CSR_DATA_BITS         = 64;
   localparam int QUEUE_DEPTH           = 2;

   // UTF-8 lead byte that is stripped from the text (-61 as a signed byte)
   localparam logic [7:0] DROP_BYTE = 8'hC3;

   typedef enum logic [1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2
   } csr_reg_type;

   // One classified text byte as it travels from front to back
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic       keep;
   } smp_item_type;

endpackage
`default_nettype wire

>>> rtl/smp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Small register queue; DEPTH must be a power of two, at least 2.
module smp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = smp_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/smp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Classify each incoming byte and queue it for the back end.
module smp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_push,
   output logic                      in_full,
   input  wire logic [7:0]           in_text_byte,
   input  wire logic                 in_last_byte,
   input  wire logic                 item_pop,
   output smp_pkg::smp_item_type     item,
   output logic                      item_empty
);
   smp_pkg::smp_item_type classified;

   // Mark the stripped lead byte; it still carries the last flag.
   always_comb begin
      classified.text_byte = in_text_byte;
      classified.last_byte = in_last_byte;
      classified.keep      = (in_text_byte != smp_pkg::DROP_BYTE);
   end

   smp_fifo #(
      .WIDTH ($bits(smp_pkg::smp_item_type)),
      .DEPTH (smp_pkg::QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (in_push),
      .push_data (classified),
      .full      (in_full),
      .pop       (item_pop),
      .pop_data  (item),
      .empty     (item_empty)
   );

endmodule
`default_nettype wire

>>> rtl/smp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Window shift, parallel pattern compare, position and match counters.
module smp_back #(
   parameter int PATTERN_MAX   = smp_pkg::PATTERN_MAX_DEFAULT,
   parameter int POSITION_BITS = smp_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire smp_pkg::smp_item_type             item,
   input  wire logic                              item_empty,
   output logic                                   item_pop,
   input  wire logic [smp_pkg::PATTERN_BITS-1:0]  pattern_bits,
   input  wire logic [smp_pkg::LEN_BITS-1:0]      pattern_length,
   input  wire logic                              res_full,
   output logic                                   res_push,
   output logic                                   res_match_found,
   output logic [POSITION_BITS-1:0]               res_match_start,
   output logic [POSITION_BITS-1:0]               res_match_end,
   output logic [POSITION_BITS-1:0]               res_match_total,
   output logic                                   res_text_done
);
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LW    = smp_pkg::LEN_BITS;
   localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;

   logic [7:0]               window_ff [PATTERN_MAX];
   logic [7:0]               window_in [PATTERN_MAX];
   logic [POSITION_BITS-1:0] kept_ff, kept_in;
   logic [POSITION_BITS-1:0] found_ff, found_in;
   logic [POSITION_BITS-1:0] len_pos;
   logic                     advance, all_ok, len_ok, match;

   assign advance  = !item_empty && !res_full;
   assign item_pop = advance;
   assign len_pos  = POSITION_BITS'(pattern_length);

   // Shift the new byte in at the near end of the window.
   always_comb begin
      window_in[0] = item.text_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   // Compare pattern byte k against the window slot len-1-k.
   always_comb begin
      logic [LW-1:0]    slot;
      logic [7:0]       pat;
      all_ok = 1'b1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         slot = pattern_length - LW'(k) - LW'(1);
         pat  = (k < 16) ? pattern_bits[8*(k%16) +: 8] : 8'h00;
         if ((LW+1)'(k) < {1'b0, pattern_length}) begin
            if (window_in[slot[IDX_W-1:0]] != pat) begin
               all_ok = 1'b0;
            end
         end
      end
   end

   always_comb begin
      kept_in = kept_ff;
      if (item.keep && kept_ff != POS_LIMIT) begin
         kept_in = kept_ff + POSITION_BITS'(1);
      end
      len_ok = (pattern_length != '0) &&
               ({1'b0, pattern_length} <= (LW+1)'(PATTERN_MAX));
      match  = item.keep && len_ok && (kept_in >= len_pos) && all_ok;
      found_in = found_ff;
      if (match && found_ff != POS_LIMIT) begin
         found_in = found_ff + POSITION_BITS'(1);
      end
   end

   assign res_push        = advance && (match || item.last_byte);
   assign res_match_found = match;
   assign res_match_end   = match ? kept_in : '0;
   assign res_match_start = match ? kept_in - len_pos + POSITION_BITS'(1) : '0;
   assign res_match_total = found_in;
   assign res_text_done   = item.last_byte;

   // Window contents below the kept count are never compared; no reset needed.
   always_ff @(posedge clock) begin
      if (advance && item.keep) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff  <= '0;
         found_ff <= '0;
      end else if (advance) begin
         if (item.last_byte) begin
            kept_ff  <= '0;
            found_ff <= '0;
         end else begin
            kept_ff  <= kept_in;
            found_ff <= found_in;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/substring_match_positions.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake              Beat payload
// req_     in         push / full            text_byte, last_byte
// rsp_     out        pop / empty            match_found, match_start, match_end,
//                                            match_total, text_done
// csr_     in/out     APB psel/penable       pattern_low, pattern_high, pattern_length
//
// One text byte a cycle sustained while the result queue has room; a result beat
// passes the front queue, then the compare stage writing the result queue.
// The full window compare, position and count update all happen in the same back-end cycle.
// Reset is synchronous and clears the queues, counters and configuration registers.
// A full result queue stalls the back end, which then backs up the front queue
// and raises req_full; each side stalls on its own otherwise.
module substring_match_positions #(
   parameter int PATTERN_MAX   = smp_pkg::PATTERN_MAX_DEFAULT,
   parameter int POSITION_BITS = smp_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // text byte input
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire logic [7:0]                         req_text_byte,
   input  wire logic                               req_last_byte,
   // results
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic                                    rsp_match_found,
   output logic [POSITION_BITS-1:0]                rsp_match_start,
   output logic [POSITION_BITS-1:0]                rsp_match_end,
   output logic [POSITION_BITS-1:0]                rsp_match_total,
   output logic                                    rsp_text_done,
   // configuration
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [smp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [smp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [smp_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                    csr_pready
);
   `include "substring_match_positions_macros.svh"

   localparam int RES_W = 3 * POSITION_BITS + 2;

   // Configuration registers
   logic [63:0]                   pattern_low_ff;
   logic [63:0]                   pattern_high_ff;
   logic [smp_pkg::LEN_BITS-1:0]  pattern_length_ff;
   logic                          csr_write;
   smp_pkg::csr_reg_type          csr_sel;

   // Front-to-back queue
   smp_pkg::smp_item_type         item;
   logic                          item_empty, item_pop;

   // Back end to result queue
   logic                          res_full, res_push;
   logic                          res_match_found, res_text_done;
   logic [POSITION_BITS-1:0]      res_match_start, res_match_end, res_match_total;
   logic [RES_W-1:0]              res_word, rsp_word;

   // Registers sit 8 bytes apart; decode on the register slot and drop the low bits.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = smp_pkg::csr_reg_type'(csr_paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write) begin
         case (csr_sel)
            smp_pkg::CSR_PATTERN_LOW: begin
               pattern_low_ff <= csr_pwdata;
            end
            smp_pkg::CSR_PATTERN_HIGH: begin
               pattern_high_ff <= csr_pwdata;
            end
            smp_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_pwdata[smp_pkg::LEN_BITS-1:0];
            end
            default: begin
               // unmapped slot: drop the write
            end
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         smp_pkg::CSR_PATTERN_LOW:    csr_prdata = pattern_low_ff;
         smp_pkg::CSR_PATTERN_HIGH:   csr_prdata = pattern_high_ff;
         smp_pkg::CSR_PATTERN_LENGTH: csr_prdata = 64'(pattern_length_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // Front: tag stripped bytes and queue every accepted beat.
   smp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_push      (req_push),
      .in_full      (req_full),
      .in_text_byte (req_text_byte),
      .in_last_byte (req_last_byte),
      .item_pop     (item_pop),
      .item         (item),
      .item_empty   (item_empty)
   );

   // Back: advance the window and counters, emit a result on a match or last byte.
   smp_back #(
      .PATTERN_MAX   (PATTERN_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item            (item),
      .item_empty      (item_empty),
      .item_pop        (item_pop),
      .pattern_bits    ({pattern_high_ff, pattern_low_ff}),
      .pattern_length  (pattern_length_ff),
      .res_full        (res_full),
      .res_push        (res_push),
      .res_match_found (res_match_found),
      .res_match_start (res_match_start),
      .res_match_end   (res_match_end),
      .res_match_total (res_match_total),
      .res_text_done   (res_text_done)
   );

   assign res_word = {res_match_found, res_match_start, res_match_end,
                      res_match_total, res_text_done};

   // Result queue: hold finished beats until the consumer pops them.
   smp_fifo #(
      .WIDTH (RES_W),
      .DEPTH (smp_pkg::QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_word),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_word),
      .empty     (rsp_empty)
   );

   assign rsp_match_found = rsp_word[RES_W-1];
   assign rsp_match_start = rsp_word[RES_W-2 -: POSITION_BITS];
   assign rsp_match_end   = rsp_word[RES_W-2-POSITION_BITS -: POSITION_BITS];
   assign rsp_match_total = rsp_word[POSITION_BITS:1];
   assign rsp_text_done   = rsp_word[0];

   // The back end never writes into a full result queue.
   `SMP_ASSERT_NOW(a_no_push_when_full, clock, reset, res_push, !res_full, "result push into full queue")
   // A beat without a match is only ever the end-of-text beat, with zero positions.
   `SMP_ASSERT_NOW(a_nomatch_is_done, clock, reset, !rsp_empty && !rsp_match_found, rsp_text_done && rsp_match_start == '0 && rsp_match_end == '0, "non-match result not end of text")
   // A match beat always counts at least one occurrence and starts no later than it ends.
   `SMP_ASSERT_NOW(a_match_counted, clock, reset, !rsp_empty && rsp_match_found, rsp_match_total != '0 && rsp_match_start <= rsp_match_end && rsp_match_start != '0, "match result fields inconsistent")
   // Reset leaves both queues empty.
   `SMP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty && !req_full, "queues not empty after reset")

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for substring_match_positions.
//
// A byte stream goes into the req_ queue and the block reports every pattern
// occurrence, plus a closing beat on the byte flagged last. A predictor in this
// file tracks the kept-byte window, the position and the match count, and it
// queues the report each accepted byte should cause. A checker pops those
// reports in order against every beat taken from the rsp_ queue.
//
// Test tasks run in turn: matching switched off, overlapping occurrences,
// extreme byte values and a dropped closing byte, a full 16-byte pattern, a
// length beyond the window, and random traffic in four idling phases. The
// pattern registers change only while the block is idle. Each write is read
// back on the APB port.
module testbench;

   localparam int POS_W = smp_pkg::POSITION_BITS_DEFAULT;
   localparam int WIN_LEN = smp_pkg::PATTERN_MAX_DEFAULT;
   localparam logic [POS_W-1:0] POS_CEILING = '1;
   localparam int MAX_SHOWN = 10;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_B = 8'h62;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] stop_pos;
      logic [POS_W-1:0] total;
      logic             done;
   } match_report_type;

   // Drive every input to a known value from time zero.
   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_push = 1'b0;
   logic                              req_full;
   logic [7:0]                        req_text_byte = '0;
   logic                              req_last_byte = 1'b0;
   logic                              rsp_empty;
   logic                              rsp_pop = 1'b0;
   logic                              rsp_match_found;
   logic [POS_W-1:0]                  rsp_match_start;
   logic [POS_W-1:0]                  rsp_match_end;
   logic [POS_W-1:0]                  rsp_match_total;
   logic                              rsp_text_done;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [smp_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [smp_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [smp_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   substring_match_positions dut (.*);

   // Predictor copy of the registers and the per-text state.
   logic [63:0]                  pattern_lo_q = '0;
   logic [63:0]                  pattern_hi_q = '0;
   logic [smp_pkg::LEN_BITS-1:0] pattern_len_q = '0;
   logic [7:0]                   recent_text [WIN_LEN];
   logic [POS_W-1:0]             kept_bytes;
   logic [POS_W-1:0]             hits_so_far;

   // Reports still owed by the block, oldest first.
   match_report_type pending_reports [$];

   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Clear the window, position and count, as the block does after a last byte.
   function automatic void forget_text();
      for (int i = 0; i < WIN_LEN; i++) recent_text[i] = 8'h00;
      kept_bytes = '0;
      hits_so_far = '0;
   endfunction

   // Pattern byte k; byte 0 is the first character, bytes past the registers read as zero.
   function automatic logic [7:0] pattern_char(int k);
      logic [127:0] pattern_bits;
      pattern_bits = {pattern_hi_q, pattern_lo_q};
      if (k < 16) begin
         return pattern_bits[8*k +: 8];
      end
      return 8'h00;
   endfunction

   // Advance the window by one text byte and queue the report it causes, if any.
   function automatic void scan_text_byte(logic [7:0] text_byte, logic last_byte);
      match_report_type report;
      int               len;
      report = '0;
      len = int'(pattern_len_q);
      if (text_byte != smp_pkg::DROP_BYTE) begin
         for (int i = WIN_LEN - 1; i > 0; i--) recent_text[i] = recent_text[i - 1];
         recent_text[0] = text_byte;
         if (kept_bytes != POS_CEILING) kept_bytes++;
         // Length zero and lengths past the window never match.
         if (len != 0 && len <= WIN_LEN && int'(kept_bytes) >= len) begin
            report.found = 1'b1;
            for (int k = 0; k < len; k++) begin
               if (recent_text[len - 1 - k] != pattern_char(k)) report.found = 1'b0;
            end
         end
         if (report.found) begin
            report.stop_pos = kept_bytes;
            report.start_pos = kept_bytes - POS_W'(len) + 1'b1;
            if (hits_so_far != POS_CEILING) hits_so_far++;
         end
      end
      report.total = hits_so_far;
      report.done = last_byte;
      if (report.found || last_byte) pending_reports.push_back(report);
      if (last_byte) forget_text();
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_SHOWN) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
         end
      end
   endfunction

   function automatic void set_idling(int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
   endfunction

   // Receiver: decide pop at each falling edge; stall at the phase's rate.
   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Checker: compare every accepted result beat with the oldest owed report.
   always @(posedge clock) begin
      match_report_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN) begin
               $display("%0t: result beat with nothing owed: found=%0d start=%0d end=%0d",
                        $time, rsp_match_found, rsp_match_start, rsp_match_end);
            end
         end else begin
            want = pending_reports.pop_front();
            check_field("match_found", want.found, rsp_match_found);
            check_field("match_start", want.start_pos, rsp_match_start);
            check_field("match_end", want.stop_pos, rsp_match_end);
            check_field("match_total", want.total, rsp_match_total);
            check_field("text_done", want.done, rsp_text_done);
         end
      end
   end

   // Send one text byte: idle at random first, hold the beat until the queue takes it.
   // Entered and left at a falling edge; push stays high for a following beat.
   task automatic push_text_byte(input logic [7:0] text_byte, input logic last_byte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         req_text_byte <= 8'($urandom);
         req_last_byte <= 1'($urandom);
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_text_byte <= text_byte;
      req_last_byte <= last_byte;
      do @(posedge clock); while (req_full);
      scan_text_byte(text_byte, last_byte);
      @(negedge clock);
   endtask

   // Drop push, let every owed report land, then cover the pipeline latency
   // of bytes that cause no report.
   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write of one register, then a read back of the same address.
   task automatic write_csr(input smp_pkg::csr_reg_type which, input logic [63:0] value);
      logic [63:0] read_back;
      logic [63:0] keep_mask;
      keep_mask = (which == smp_pkg::CSR_PATTERN_LENGTH) ? 64'(5'h1F) : '1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= smp_pkg::CSR_ADDR_BITS'({which, 3'b000});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (which)
         smp_pkg::CSR_PATTERN_LOW: begin
            pattern_lo_q = value;
         end
         smp_pkg::CSR_PATTERN_HIGH: begin
            pattern_hi_q = value;
         end
         smp_pkg::CSR_PATTERN_LENGTH: begin
            pattern_len_q = value[smp_pkg::LEN_BITS-1:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      read_back = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      check_field("csr read back", value & keep_mask, read_back & keep_mask);
      // Leave the bus idle before a following write so it starts clean.
      @(negedge clock);
   endtask

   task automatic load_pattern(input logic [127:0] pattern_bits, input int len);
      write_csr(smp_pkg::CSR_PATTERN_LOW, pattern_bits[63:0]);
      write_csr(smp_pkg::CSR_PATTERN_HIGH, pattern_bits[127:64]);
      write_csr(smp_pkg::CSR_PATTERN_LENGTH, 64'(len));
   endtask

   // Mostly two-letter patterns so occurrences overlap; odd lengths now and then.
   task automatic load_random_pattern();
      logic [127:0] pattern_bits;
      int           len;
      for (int k = 0; k < 16; k++) begin
         pattern_bits[8*k +: 8] = 8'($urandom);
         if ($urandom_range(3) != 0) begin
            pattern_bits[8*k +: 8] = 8'(CHAR_LOWER_A + $urandom_range(0, 1));
         end
      end
      case ($urandom_range(0, 9))
         0: len = 0;
         1: len = 1;
         2: len = WIN_LEN;
         3: len = $urandom_range(0, 1) ? 17 : 31;
         default: len = $urandom_range(2, 6);
      endcase
      load_pattern(pattern_bits, len);
   endtask

   // Straight after reset the length is zero: nothing matches, only the last byte reports.
   task automatic test_disabled_pattern();
      push_text_byte(CHAR_LOWER_A, 1'b0);
      push_text_byte(8'h00, 1'b0);
      push_text_byte(8'hFF, 1'b1);
   endtask

   // "aba" against "ab<drop>aba": both overlapping hits, the dropped byte not counted.
   task automatic test_overlapping_matches();
      drain_results();
      load_pattern(128'h616261, 3);
      push_text_byte(CHAR_LOWER_A, 1'b0);
      push_text_byte(CHAR_LOWER_B, 1'b0);
      push_text_byte(smp_pkg::DROP_BYTE, 1'b0);
      push_text_byte(CHAR_LOWER_A, 1'b0);
      push_text_byte(CHAR_LOWER_B, 1'b0);
      push_text_byte(CHAR_LOWER_A, 1'b1);
   endtask

   // Bytes 0x00 and 0xFF as pattern and text; then a text closed by a dropped byte.
   task automatic test_extreme_bytes();
      drain_results();
      load_pattern({{15{8'hFF}}, 8'h00}, 2);
      push_text_byte(8'h00, 1'b0);
      push_text_byte(8'hFF, 1'b0);
      push_text_byte(8'h00, 1'b0);
      push_text_byte(8'hFF, 1'b1);
      push_text_byte(8'h00, 1'b0);
      push_text_byte(smp_pkg::DROP_BYTE, 1'b1);
   endtask

   // Sixteen-byte pattern: nothing before the window fills, a hit and done together.
   task automatic test_full_width_pattern();
      logic [127:0] pattern_bits;
      for (int k = 0; k < 16; k++) begin
         pattern_bits[8*k +: 8] = 8'($urandom);
         if (pattern_bits[8*k +: 8] == smp_pkg::DROP_BYTE) pattern_bits[8*k +: 8] = 8'h00;
      end
      drain_results();
      load_pattern(pattern_bits, WIN_LEN);
      for (int k = 0; k < 16; k++) push_text_byte(pattern_bits[8*k +: 8], k == 15);
   endtask

   // Length 17 with an all-zero pattern and zero text: must still never match.
   task automatic test_oversize_length();
      drain_results();
      load_pattern('0, 17);
      for (int k = 0; k < 17; k++) push_text_byte(8'h00, k == 16);
   endtask

   // Texts built mostly from whole or cut-short pattern copies, with dropped
   // bytes spliced in and random noise between. Halfway, pause the sender until
   // all reports are in and swap the pattern with the text still open.
   task automatic run_random_phase(input int budget);
      logic [7:0] burst [$];
      logic [7:0] next_char;
      int         text_left;
      int         cut;
      int         roll;
      drain_results();
      load_random_pattern();
      text_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 48);
      for (int sent = 0; sent < budget; sent++) begin
         if (sent == budget / 2) begin
            drain_results();
            load_random_pattern();
            burst.delete();
         end
         if (burst.size() == 0 && $urandom_range(99) < 35) begin
            cut = int'(pattern_len_q);
            if (cut > WIN_LEN) cut = WIN_LEN;
            if (cut == 0) cut = 1;
            if ($urandom_range(3) == 0) cut = $urandom_range(1, cut);
            for (int k = 0; k < cut; k++) burst.push_back(pattern_char(k));
         end
         roll = $urandom_range(99);
         if (roll < 8) begin
            next_char = smp_pkg::DROP_BYTE;
         end else if (burst.size() != 0) begin
            next_char = burst.pop_front();
         end else if (roll < 60) begin
            next_char = pattern_char($urandom_range(0, 15));
         end else begin
            next_char = 8'($urandom);
         end
         push_text_byte(next_char, text_left == 1);
         text_left--;
         if (text_left == 0) begin
            text_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4)
                                                   : $urandom_range(5, 48);
         end
      end
   endtask

   task automatic test_random_traffic();
      set_idling(0, 0);
      run_random_phase(125);
      set_idling(66, 0);
      run_random_phase(125);
      set_idling(0, 66);
      run_random_phase(125);
      set_idling(17, 17);
      run_random_phase(125);
   endtask

   initial begin
      forget_text();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_disabled_pattern();
      test_overlapping_matches();
      test_extreme_bytes();
      test_full_width_pattern();
      test_oversize_length();
      test_random_traffic();
      drain_results();
      // Keep the clock running to catch any stray beat.
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending_reports.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/smp_pkg.sv
rtl/smp_fifo.sv
rtl/smp_front.sv
rtl/smp_back.sv
rtl/substring_match_positions.sv
dv/testbench.sv
